[design/nsv_pkg.sv]
// Shared types, character codes and sentence type table for the NMEA sentence validator.
package nsv_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam logic [2:0] TYPE_GGA  = 3'd0;
    localparam logic [2:0] TYPE_RMC  = 3'd1;
    localparam logic [2:0] TYPE_GLL  = 3'd2;
    localparam logic [2:0] TYPE_GSA  = 3'd3;
    localparam logic [2:0] TYPE_GSV  = 3'd4;
    localparam logic [2:0] TYPE_VTG  = 3'd5;
    localparam logic [2:0] TYPE_NONE = 3'd6;

    localparam int NUM_TYPES = 6;

    // indexed by type code
    localparam logic [23:0] TYPE_TABLE [NUM_TYPES] = '{
        24'h474741,  // GGA
        24'h524D43,  // RMC
        24'h474C4C,  // GLL
        24'h475341,  // GSA
        24'h475356,  // GSV
        24'h565447   // VTG
    };

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_digit;

    typedef struct packed {
        logic       sentence_ok;
        logic [2:0] type_code;
        logic       checksum_ok;
    } t_result;

    function automatic t_digit hex_value(input logic [7:0] c);
        t_digit d;
        d = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.valid = 1'b1;
            d.value = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d.valid = 1'b1;
            d.value = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d.valid = 1'b1;
            d.value = 4'(c - 8'h57);
        end
        return d;
    endfunction

endpackage

[design/nsv_if.sv]
// Valid/ready stream interfaces for received bytes and sentence results.
interface nsv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsv_result_if;
    logic       valid;
    logic       ready;
    logic       sentence_ok;
    logic [2:0] type_code;
    logic       checksum_ok;

    modport source (output valid, output sentence_ok, output type_code,
                    output checksum_ok, input ready);
    modport sink   (input valid, input sentence_ok, input type_code,
                    input checksum_ok, output ready);
endinterface

[design/nsv_in_reg.sv]
// Input register: holds one received byte until the line tracker consumes it.
module nsv_in_reg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nsv_byte_if.sink    i_rx,
    input  logic        i_take,
    output logic        o_valid,
    output logic [7:0]  o_byte
);
    logic       r_valid;
    logic [7:0] r_byte;
    logic       n_valid;
    logic       w_load;

    assign i_rx.ready = !r_valid || i_take;
    assign w_load     = i_rx.valid && i_rx.ready;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
endmodule

[design/nsv_line.sv]
// Sentence framing state, running checksum and end-of-line classification.
module nsv_line #(
    parameter int LINE_CAPACITY = 128
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic [7:0]      i_byte,
    output logic            o_emit,
    output nsv_pkg::t_result o_result
);
    import nsv_pkg::*;

    localparam int CW = $clog2(LINE_CAPACITY);
    localparam logic [CW-1:0] LAST_POS = CW'(LINE_CAPACITY - 1);

    logic          r_in;
    logic [CW-1:0] r_count;
    logic [7:0]    r_xor;
    logic          r_star;
    logic [CW-1:0] r_star_idx;
    logic [23:0]   r_type;
    t_digit        r_hi;
    t_digit        r_lo;

    logic          n_in;
    logic [CW-1:0] n_count;
    logic [7:0]    n_xor;
    logic          n_star;
    logic [CW-1:0] n_star_idx;
    logic [23:0]   n_type;
    t_digit        n_hi;
    t_digit        n_lo;

    // line contents after appending the current byte
    logic [CW-1:0] u_count;
    logic [7:0]    u_xor;
    logic          u_star;
    logic [CW-1:0] u_star_idx;
    logic [23:0]   u_type;
    t_digit        u_hi;
    t_digit        u_lo;

    logic          w_dollar;
    logic          w_term;
    logic          w_append;
    logic          w_drop;
    logic [CW:0]   w_idx1;
    logic [CW:0]   w_idx2;
    logic [CW-1:0] w_hdr_len;
    logic [2:0]    w_code;
    logic          w_csum;

    assign w_dollar = (i_byte == CH_DOLLAR);
    assign w_term   = (i_byte == CH_CR) || (i_byte == CH_LF);
    assign w_drop   = !w_dollar && r_in && (r_count >= LAST_POS);
    assign w_append = !w_dollar && r_in && !(r_count >= LAST_POS);
    assign w_idx1   = {1'b0, r_star_idx} + (CW+1)'(1);
    assign w_idx2   = {1'b0, r_star_idx} + (CW+1)'(2);

    always_comb begin
        u_count    = r_count + CW'(1);
        u_xor      = r_xor;
        u_star     = r_star;
        u_star_idx = r_star_idx;
        u_type     = r_type;
        u_hi       = r_hi;
        u_lo       = r_lo;
        if (r_count == CW'(3)) begin
            u_type[23:16] = i_byte;
        end else if (r_count == CW'(4)) begin
            u_type[15:8] = i_byte;
        end else if (r_count == CW'(5)) begin
            u_type[7:0] = i_byte;
        end
        if (r_star) begin
            if ({1'b0, r_count} == w_idx1) begin
                u_hi = hex_value(i_byte);
            end else if ({1'b0, r_count} == w_idx2) begin
                u_lo = hex_value(i_byte);
            end
        end else if (i_byte == CH_STAR) begin
            u_star     = 1'b1;
            u_star_idx = r_count;
        end else begin
            u_xor = r_xor ^ i_byte;
        end
    end

    always_comb begin
        w_hdr_len = u_star ? u_star_idx : u_count;
        w_code    = TYPE_NONE;
        if (w_hdr_len >= CW'(6)) begin
            for (int k = NUM_TYPES - 1; k >= 0; k--) begin
                if (u_type == TYPE_TABLE[k]) begin
                    w_code = 3'(k);
                end
            end
        end
        w_csum = (u_count >= CW'(7)) && u_star && u_hi.valid && u_lo.valid
                 && ({u_hi.value, u_lo.value} == u_xor);
    end

    assign o_emit               = w_append && w_term;
    assign o_result.type_code   = w_code;
    assign o_result.checksum_ok = w_csum;
    assign o_result.sentence_ok = w_csum && (w_code != TYPE_NONE);

    always_comb begin
        n_in       = r_in;
        n_count    = r_count;
        n_xor      = r_xor;
        n_star     = r_star;
        n_star_idx = r_star_idx;
        n_type     = r_type;
        n_hi       = r_hi;
        n_lo       = r_lo;
        if (w_dollar || w_drop || (w_append && w_term)) begin
            n_in       = w_dollar;
            n_count    = w_dollar ? CW'(1) : '0;
            n_xor      = '0;
            n_star     = 1'b0;
            n_star_idx = '0;
            n_type     = '0;
            n_hi       = '0;
            n_lo       = '0;
        end else if (w_append) begin
            n_count    = u_count;
            n_xor      = u_xor;
            n_star     = u_star;
            n_star_idx = u_star_idx;
            n_type     = u_type;
            n_hi       = u_hi;
            n_lo       = u_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in       <= 1'b0;
            r_count    <= '0;
            r_xor      <= '0;
            r_star     <= 1'b0;
            r_star_idx <= '0;
            r_type     <= '0;
            r_hi       <= '0;
            r_lo       <= '0;
        end else if (i_fire) begin
            r_in       <= n_in;
            r_count    <= n_count;
            r_xor      <= n_xor;
            r_star     <= n_star;
            r_star_idx <= n_star_idx;
            r_type     <= n_type;
            r_hi       <= n_hi;
            r_lo       <= n_lo;
        end
    end
endmodule

[design/nsv_out_reg.sv]
// Result register driving the result stream.
module nsv_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  nsv_pkg::t_result i_result,
    output logic             o_free,
    nsv_result_if.source     o_res
);
    import nsv_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_free = !r_valid || o_res.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_res.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.sentence_ok = r_result.sentence_ok;
    assign o_res.type_code   = r_result.type_code;
    assign o_res.checksum_ok = r_result.checksum_ok;
endmodule

[design/nmea_sentence_validator.sv]
// Top level of the NMEA sentence validator.
// Takes one received byte per beat and frames NMEA sentences: '$' starts a
// sentence, CR or LF ends it with one result beat giving the sentence type
// (GGA, RMC, GLL, GSA, GSV, VTG or unsupported) and whether the "*hh"
// checksum matches. A byte is registered on input, processed against the line
// state when it leaves the input register, and the result lands in an output
// register, so the block takes one byte per cycle unless a terminator is waiting
// for the output register. A byte that ends a sentence waits in the input
// register only while the output register holds an untaken result.
// A line that would grow past LINE_CAPACITY-1 characters, counting '$' and
// the terminator, is dropped silently.
module nmea_sentence_validator #(
    parameter int LINE_CAPACITY = 128
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    nsv_byte_if.sink     i_rx,
    nsv_result_if.source o_res
);
    import nsv_pkg::*;

    logic       w_in_valid;
    logic [7:0] w_in_byte;
    logic       w_emit;
    logic       w_free;
    logic       w_fire;
    t_result    w_result;

    assign w_fire = w_in_valid && (!w_emit || w_free);

    nsv_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (w_fire),
        .o_valid (w_in_valid),
        .o_byte  (w_in_byte)
    );

    nsv_line #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_line (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_byte   (w_in_byte),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    nsv_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_fire && w_emit),
        .i_result (w_result),
        .o_free   (w_free),
        .o_res    (o_res)
    );
endmodule

[design/nsv_checker.sv]
// Port-level assertions for the NMEA sentence validator, bound to the top level.
module nsv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_sentence_ok,
    input logic [2:0] i_type_code,
    input logic       i_checksum_ok
);
    import nsv_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable({i_sentence_ok, i_type_code, i_checksum_ok}))
        else $error("result beat changed while stalled");

    a_ok_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_sentence_ok == (i_checksum_ok && i_type_code != TYPE_NONE))
        else $error("sentence_ok disagrees with type and checksum");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_type_code <= TYPE_NONE)
        else $error("type_code out of range");
endmodule

bind nmea_sentence_validator nsv_checker u_nsv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_sentence_ok (o_res.sentence_ok),
    .i_type_code   (o_res.type_code),
    .i_checksum_ok (o_res.checksum_ok)
);
